@@ rtl/sparse_table_range_min_unit_assert.svh @@
// Assertion macros for the sparse table range minimum unit.
// Included by the top level; expects clk and rst_n in scope.
`ifndef SPARSE_TABLE_RANGE_MIN_UNIT_ASSERT_SVH
`define SPARSE_TABLE_RANGE_MIN_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define STRM_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sparse table assertion failed");

// Next-cycle implication, checked out of reset.
`define STRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sparse table assertion failed");

`endif

@@ rtl/strm_pkg.sv @@
// Shared types, mode codes and helper functions for the sparse table unit.
// No dependencies.
package strm_pkg;

  // Transaction modes
  localparam logic [1:0] MODE_APPEND      = 2'd0;
  localparam logic [1:0] MODE_RAPPEND     = 2'd1;
  localparam logic [1:0] MODE_QUERY_END   = 2'd2;
  localparam logic [1:0] MODE_QUERY_START = 2'd3;

  // Width of window lengths (up to 65536 positions) and of a level index
  localparam int LEN_W     = 17;
  localparam int LVL_IDX_W = 5;

  typedef struct packed {
    logic [1:0]         mode;
    logic [9:0]         left_pos;
    logic [9:0]         right_pos;
    logic signed [31:0] value;
  } strm_in_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               error;
  } strm_out_t;

  // Position of the leading one; zero for zero
  function automatic logic [LVL_IDX_W-1:0] lead_one(input logic [LEN_W-1:0] x);
    logic [LVL_IDX_W-1:0] k;
    k = '0;
    for (int i = 0; i < LEN_W; i++) begin
      if (x[i]) k = LVL_IDX_W'(i);
    end
    return k;
  endfunction

  // Signed minimum
  function automatic logic signed [31:0] smin(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

@@ rtl/strm_mem.sv @@
// Simple dual-port synchronous RAM holding the sparse table entries.
// One write and one registered read per cycle; no dependencies.
module strm_mem #(
  parameter int AW = 14,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/sparse_table_range_min_unit.sv @@
// Sparse table range minimum unit: sequencer around one table RAM.
// Depends on strm_pkg, strm_mem and sparse_table_range_min_unit_assert.svh.
//
// Holds one signed 32-bit entry per position and level in a single RAM (entry address is
// position concatenated with level). After reset the unit sweeps the RAM to zero, one entry
// a cycle, and takes no transaction until done. One transaction is processed at a time. An
// append or rappend writes level zero and then fills each upper level up to its top (up to
// 10 upper levels at the defaults): each level needs one read of an older entry through the
// single read port, whose registered output paces the per-level steps. A query makes two
// reads through the same port. An error transaction goes straight to the finish state. The
// result sits in an output register, so the next transaction is taken while it waits for
// the consumer.
module sparse_table_range_min_unit #(
  parameter int NUM_POS    = 1024,
  parameter int NUM_LEVELS = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  strm_pkg::strm_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output strm_pkg::strm_out_t out_data
);

  localparam int PW = $clog2(NUM_POS);
  localparam int LW = $clog2(NUM_LEVELS);
  localparam int AW = PW + LW;
  localparam int IW = strm_pkg::LVL_IDX_W;
  localparam int NW = strm_pkg::LEN_W;
  localparam logic [IW-1:0] TOP_LVL  = IW'(NUM_LEVELS - 1);
  localparam logic [PW:0]   ONE_W    = (PW+1)'(1);
  localparam logic [NW-1:0] NUM_POS_W = NW'(NUM_POS);

  // State codes
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_APP   = 3'd2;
  localparam logic [2:0] ST_QA    = 3'd3;
  localparam logic [2:0] ST_QB    = 3'd4;
  localparam logic [2:0] ST_QC    = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  strm_pkg::strm_out_t out_data_r;
  logic [1:0]          mode_r, mode_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [PW-1:0]       pos2_r, pos2_nxt;
  logic [PW-1:0]       step_r, step_nxt;
  logic [LW-1:0]       lvl_r, lvl_nxt;
  logic [LW-1:0]       top_r, top_nxt;
  logic signed [31:0]  cur_r, cur_nxt;
  logic signed [31:0]  res_r, res_nxt;
  logic                err_r, err_nxt;

  logic                fin_load;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [31:0]         wr_data;
  logic [AW-1:0]       rd_addr;
  logic signed [31:0]  rd_data;

  // Input decode
  logic [31:0]         in_l32, in_r32;
  logic [PW-1:0]       in_l_pos, in_r_pos;
  logic                l_oob, r_oob, rev;
  logic                is_app;
  logic [NW-1:0]       app_len, qry_len;
  logic [IW-1:0]       app_k, qry_k;
  logic [LW-1:0]       app_top, qry_lvl;
  logic [PW:0]         span;
  logic [PW:0]         qb_wide;
  logic [PW-1:0]       qa_pos;
  logic signed [31:0]  app_min;

  assign in_l32   = 32'(in_data.left_pos);
  assign in_r32   = 32'(in_data.right_pos);
  assign in_l_pos = in_l32[PW-1:0];
  assign in_r_pos = in_r32[PW-1:0];
  assign l_oob    = (in_l32 >= 32'(NUM_POS));
  assign r_oob    = (in_r32 >= 32'(NUM_POS));
  assign rev      = (in_data.right_pos < in_data.left_pos);
  assign is_app   = (in_data.mode == strm_pkg::MODE_APPEND) ||
                    (in_data.mode == strm_pkg::MODE_RAPPEND);

  // Number of levels to fill, clamped to the top level
  assign app_len = (in_data.mode == strm_pkg::MODE_RAPPEND) ?
                   (NUM_POS_W - NW'(in_data.left_pos)) :
                   (NW'(in_data.left_pos) + NW'(1));
  assign app_k   = strm_pkg::lead_one(app_len);
  assign app_top = (app_k > TOP_LVL) ? TOP_LVL[LW-1:0] : app_k[LW-1:0];

  // Query level from the range length
  assign qry_len = NW'(in_data.right_pos) - NW'(in_data.left_pos) + NW'(1);
  assign qry_k   = strm_pkg::lead_one(qry_len);
  assign qry_lvl = (qry_k > TOP_LVL) ? TOP_LVL[LW-1:0] : qry_k[LW-1:0];

  // Window addresses for queries (lvl_r holds the query level)
  assign span    = ONE_W << lvl_r;
  assign qb_wide = (mode_r == strm_pkg::MODE_QUERY_END) ?
                   ({1'b0, pos_r} + span - ONE_W) :
                   ({1'b0, pos2_r} - span + ONE_W);
  assign qa_pos  = (mode_r == strm_pkg::MODE_QUERY_END) ? pos2_r : pos_r;

  assign app_min = strm_pkg::smin(cur_r, rd_data);

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    mode_nxt    = mode_r;
    pos_nxt     = pos_r;
    pos2_nxt    = pos2_r;
    step_nxt    = step_r;
    lvl_nxt     = lvl_r;
    top_nxt     = top_r;
    cur_nxt     = cur_r;
    res_nxt     = res_r;
    err_nxt     = err_r;
    fin_load    = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = clr_cnt_r;
    wr_data     = '0;
    rd_addr     = {pos_r, lvl_r};
    unique case (state_r)
      ST_CLEAR: begin
        wr_en = 1'b1;
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt = in_data.mode;
          if (is_app) begin
            if (l_oob) begin
              res_nxt   = '0;
              err_nxt   = 1'b1;
              state_nxt = ST_FIN;
            end else begin
              // write level zero, fetch the neighbor's level zero
              wr_en    = 1'b1;
              wr_addr  = {in_l_pos, LW'(0)};
              wr_data  = in_data.value;
              cur_nxt  = in_data.value;
              res_nxt  = in_data.value;
              err_nxt  = 1'b0;
              pos_nxt  = in_l_pos;
              top_nxt  = app_top;
              lvl_nxt  = LW'(1);
              step_nxt = PW'(1);
              rd_addr  = (in_data.mode == strm_pkg::MODE_RAPPEND) ?
                         {in_l_pos + PW'(1), LW'(0)} : {in_l_pos - PW'(1), LW'(0)};
              state_nxt = (app_top == '0) ? ST_FIN : ST_APP;
            end
          end else begin
            if (l_oob || r_oob || rev) begin
              res_nxt   = '0;
              err_nxt   = 1'b1;
              state_nxt = ST_FIN;
            end else begin
              pos_nxt   = in_l_pos;
              pos2_nxt  = in_r_pos;
              lvl_nxt   = qry_lvl;
              err_nxt   = 1'b0;
              state_nxt = ST_QA;
            end
          end
        end
      end
      ST_APP: begin
        // fold the fetched entry into this level and write it back
        wr_en   = 1'b1;
        wr_addr = {pos_r, lvl_r};
        wr_data = app_min;
        cur_nxt = app_min;
        if (lvl_r == top_r) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt = step_r << 1;
          lvl_nxt  = lvl_r + LW'(1);
          rd_addr  = (mode_r == strm_pkg::MODE_RAPPEND) ?
                     {pos_r + (step_r << 1), lvl_r} : {pos_r - (step_r << 1), lvl_r};
        end
      end
      ST_QA: begin
        rd_addr   = {qa_pos, lvl_r};
        pos2_nxt  = qb_wide[PW-1:0];
        state_nxt = ST_QB;
      end
      ST_QB: begin
        cur_nxt   = rd_data;
        rd_addr   = {pos2_r, lvl_r};
        state_nxt = ST_QC;
      end
      ST_QC: begin
        res_nxt   = strm_pkg::smin(cur_r, rd_data);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // hand off to the output register once it is free
        if (!out_valid_r || !out_stall) begin
          fin_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    pos_r  <= pos_nxt;
    pos2_r <= pos2_nxt;
    step_r <= step_nxt;
    lvl_r  <= lvl_nxt;
    top_r  <= top_nxt;
    cur_r  <= cur_nxt;
    res_r  <= res_nxt;
    err_r  <= err_nxt;
    if (fin_load) begin
      out_data_r.result <= res_r;
      out_data_r.error  <= err_r;
    end
  end

  strm_mem #(
    .AW (AW),
    .DW (32)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `include "sparse_table_range_min_unit_assert.svh"

  // A table write never lands on the entry fetched for the next level
  `STRM_ASSERT_IMPLY(a_no_rw_collide, wr_en && (state_nxt == ST_APP), rd_addr != wr_addr)
  // Level fill stays within the range set at accept
  `STRM_ASSERT_IMPLY(a_app_level, state_r == ST_APP, (lvl_r != '0) && (lvl_r <= top_r))
  // A finished transaction reaches the output register
  `STRM_ASSERT_NEXT(a_fin_load, fin_load, out_valid_r && (out_data_r.result == $past(res_r)))

endmodule
